### rtl/kcs_pkg.sv
// shared types and constants for the keyframe channel sampler
package kcs_pkg;

    localparam int MAX_KEYS     = 64;
    localparam int KEY_AW       = $clog2(MAX_KEYS);
    localparam int KEY_IDX_W    = 6;
    localparam int KEY_CNT_W    = 7;
    localparam int CFG_DATA_W   = 7;
    localparam int CFG_IDX_W    = 1;
    localparam int FRAC_W       = 16;
    localparam int DIV_CNT_W    = $clog2(FRAC_W);
    localparam int COMP_N       = 3;
    localparam int COMP_IDX_W   = $clog2(COMP_N);
    localparam int BLEND_PROD_W = 33 + FRAC_W + 1;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_PATH = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [KEY_IDX_W-1:0] key_index;
        logic [31:0]          time_value;
        logic signed [31:0]   value_x;
        logic signed [31:0]   value_y;
        logic signed [31:0]   value_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0]   out_x;
        logic signed [31:0]   out_y;
        logic signed [31:0]   out_z;
        logic [KEY_IDX_W-1:0] prev_key;
        logic                 target_property;
    } out_t;

    typedef struct packed {
        logic [31:0]        key_time;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } key_t;

    typedef logic [COMP_N-1:0][31:0] vec3_t;

endpackage

### rtl/keyframe_channel_sampler.sv
// top level: key table, search sequencer, divider and blend unit
//
// Input channel in_valid/in_stall/in_data carries load and sample transactions.
// A load writes one key into the table; the block is ready again in the next
// cycle. A sample searches the table for the last key at or before the given
// time and blends toward the following key. A sample reads the last and then
// the first key, takes binary search steps, waits on the serial divider
// (16 steps) and on the shared blend multiplier (six steps) and is then
// registered; a time that clamps to the last or the first key skips the
// search and the divider. in_stall stays high while a sample is in flight, so
// one sample is handled at a time; the next transaction can be taken in the
// same cycle as out_valid rises, so no new sample is taken before the result
// of the last one is registered. Results leave through an output register;
// loads are still taken while a result waits. If out_stall holds a result, a
// following sample finishes its work and then waits until the output register
// frees. Config writes (cfg_we, cfg_index, cfg_data) take effect at once and
// belong only to idle periods. Reset sets key_count to 1 and channel_path to 0
// and drops out_valid; the key table holds no defined contents until loaded.
module keyframe_channel_sampler (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  kcs_pkg::in_t                    in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output kcs_pkg::out_t                   out_data,
    input  logic                            cfg_we,
    input  logic [kcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import kcs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST,
        S_FIRST,
        S_SRCH,
        S_DIV,
        S_DIVW,
        S_BLEND,
        S_BLENDW,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [KEY_CNT_W-1:0]   key_count_reg;
    logic                   channel_path_reg;
    logic [31:0]            t_reg, t_next;
    logic [KEY_AW-1:0]      lo_reg, lo_next;
    logic [KEY_AW-1:0]      hi_reg, hi_next;
    logic [KEY_AW-1:0]      mid_reg, mid_next;
    key_t                   lo_key_reg, lo_key_next;
    key_t                   hi_key_reg, hi_key_next;
    logic [FRAC_W-1:0]      f_reg, f_next;
    logic                   out_valid_reg, out_valid_next;
    out_t                   out_reg, out_next;

    logic                   in_accept;
    logic                   key_we;
    logic [KEY_AW-1:0]      last_idx;
    logic [KEY_AW-1:0]      rd_addr;
    key_t                   rd_key;
    key_t                   wr_key;
    logic [KEY_AW:0]        span;
    logic [KEY_AW:0]        mid_sum;
    logic                   div_start;
    logic                   div_done;
    logic [FRAC_W-1:0]      div_quot;
    logic                   blend_start;
    logic                   blend_done;
    vec3_t                  v0;
    vec3_t                  v1;
    vec3_t                  blend_res;
    logic                   can_emit;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign key_we    = in_accept && (in_data.kind == KIND_LOAD)
                     && (32'(in_data.key_index) < 32'(MAX_KEYS));
    assign can_emit  = !out_valid_reg || !out_stall;

    // key count zero reads as one, above the table size saturates
    always_comb
    begin
        if (key_count_reg == '0)
        begin
            last_idx = '0;
        end
        else if (32'(key_count_reg) > 32'(MAX_KEYS))
        begin
            last_idx = KEY_AW'(MAX_KEYS - 1);
        end
        else
        begin
            last_idx = KEY_AW'(key_count_reg - 1'b1);
        end
    end

    always_comb
    begin
        wr_key.key_time = in_data.time_value;
        wr_key.x        = in_data.value_x;
        wr_key.y        = in_data.value_y;
        wr_key.z        = in_data.value_z;
    end

    kcs_ram #(
        .WIDTH ($bits(key_t)),
        .DEPTH (MAX_KEYS)
    ) u_keys (
        .clk   (clk),
        .we    (key_we),
        .waddr (KEY_AW'(in_data.key_index)),
        .wdata (wr_key),
        .raddr (rd_addr),
        .rdata (rd_key)
    );

    kcs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (t_reg - lo_key_reg.key_time),
        .den   (hi_key_reg.key_time - lo_key_reg.key_time),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        v0[0] = lo_key_reg.x;
        v0[1] = lo_key_reg.y;
        v0[2] = lo_key_reg.z;
        v1[0] = hi_key_reg.x;
        v1[1] = hi_key_reg.y;
        v1[2] = hi_key_reg.z;
    end

    kcs_blend u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .start (blend_start),
        .v0    (v0),
        .v1    (v1),
        .f     (f_reg),
        .done  (blend_done),
        .res   (blend_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        t_next         = t_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        lo_key_next    = lo_key_reg;
        hi_key_next    = hi_key_reg;
        f_next         = f_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        div_start      = 1'b0;
        blend_start    = 1'b0;
        rd_addr        = mid_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = last_idx;
                if (in_accept && (in_data.kind == KIND_SAMPLE))
                begin
                    t_next     = in_data.time_value;
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                rd_addr = '0;
                if (t_reg >= rd_key.key_time)
                begin
                    lo_next     = last_idx;
                    hi_next     = last_idx;
                    lo_key_next = rd_key;
                    hi_key_next = rd_key;
                    f_next      = '0;
                    state_next  = S_BLEND;
                end
                else
                begin
                    hi_next     = last_idx;
                    hi_key_next = rd_key;
                    state_next  = S_FIRST;
                end
            end
            S_FIRST:
            begin
                lo_next     = '0;
                lo_key_next = rd_key;
                if (t_reg < rd_key.key_time)
                begin
                    hi_key_next = rd_key;
                    f_next      = '0;
                    state_next  = S_BLEND;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_SRCH:
            begin
                if (rd_key.key_time <= t_reg)
                begin
                    lo_next     = mid_reg;
                    lo_key_next = rd_key;
                end
                else
                begin
                    hi_next     = mid_reg;
                    hi_key_next = rd_key;
                end
                state_next = S_DIV;
            end
            S_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    f_next     = div_quot;
                    state_next = S_BLEND;
                end
            end
            S_BLEND:
            begin
                blend_start = 1'b1;
                state_next  = S_BLENDW;
            end
            S_BLENDW:
            begin
                if (blend_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (can_emit)
                begin
                    out_next.out_x           = blend_res[0];
                    out_next.out_y           = blend_res[1];
                    out_next.out_z           = blend_res[2];
                    out_next.prev_key        = KEY_IDX_W'(lo_reg);
                    out_next.target_property = channel_path_reg;
                    out_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // keep narrowing while the bracket spans more than one key
        span    = {1'b0, hi_next} - {1'b0, lo_next};
        mid_sum = {1'b0, lo_next} + {1'b0, hi_next};
        if ((state_reg == S_FIRST || state_reg == S_SRCH) && (state_next == S_DIV)
            && (span > (KEY_AW + 1)'(1)))
        begin
            mid_next   = mid_sum[KEY_AW:1];
            rd_addr    = mid_sum[KEY_AW:1];
            state_next = S_SRCH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            key_count_reg    <= KEY_CNT_W'(1);
            channel_path_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KEY_COUNT:    key_count_reg    <= cfg_data[KEY_CNT_W-1:0];
                    CFG_CHANNEL_PATH: channel_path_reg <= cfg_data[0];
                    default:          key_count_reg    <= key_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        lo_key_reg <= lo_key_next;
        hi_key_reg <= hi_key_next;
        f_reg      <= f_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### rtl/kcs_ram.sv
// generic single-write, single-read ram with registered read data
module kcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/kcs_div.sv
// restoring serial divider producing the fractional blend factor
module kcs_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [31:0]                 num,
    input  logic [31:0]                 den,
    output logic                        done,
    output logic [kcs_pkg::FRAC_W-1:0]  quot
);
    import kcs_pkg::*;

    logic [31:0]          rem_reg;
    logic [31:0]          den_reg;
    logic [FRAC_W-1:0]    q_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [32:0]          shifted;
    logic [32:0]          trial;
    logic                 fits;

    // remainder stays below the divisor as long as the dividend starts below it
    always_comb
    begin
        shifted = {rem_reg, 1'b0};
        trial   = shifted - {1'b0, den_reg};
        fits    = !trial[32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(FRAC_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[31:0] : shifted[31:0];
            q_reg   <= {q_reg[FRAC_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

### rtl/kcs_blend.sv
// shared multiplier blending the three components one after another
module kcs_blend (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  kcs_pkg::vec3_t             v0,
    input  kcs_pkg::vec3_t             v1,
    input  logic [kcs_pkg::FRAC_W-1:0] f,
    output logic                       done,
    output kcs_pkg::vec3_t             res
);
    import kcs_pkg::*;

    logic [COMP_IDX_W-1:0]    idx_reg;
    logic                     phase_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic signed [BLEND_PROD_W-1:0] prod_reg;
    vec3_t                    res_reg;

    logic signed [32:0]             diff;
    logic signed [BLEND_PROD_W-1:0] prod;
    logic signed [BLEND_PROD_W-1:0] rounded;
    logic signed [BLEND_PROD_W-1:0] scaled;
    logic [31:0]                    res_c;

    // v0 + round((v1 - v0) * f / 2^16)
    always_comb
    begin
        diff    = $signed({v1[idx_reg][31], v1[idx_reg]})
                - $signed({v0[idx_reg][31], v0[idx_reg]});
        prod    = diff * $signed({1'b0, f});
        rounded = prod_reg + (BLEND_PROD_W'(1) << (FRAC_W - 1));
        scaled  = rounded >>> FRAC_W;
        res_c   = v0[idx_reg] + scaled[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                idx_reg   <= '0;
            end
            else if (busy_reg)
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                begin
                    if (idx_reg == COMP_IDX_W'(COMP_N - 1))
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !phase_reg)
        begin
            prod_reg <= prod;
        end
        if (busy_reg && phase_reg)
        begin
            res_reg[idx_reg] <= res_c;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

### rtl/kcs_checker.sv
// port-level checks for the keyframe channel sampler, bound to the top level
module kcs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input kcs_pkg::in_t                    in_data,
    input logic                            out_valid,
    input logic                            out_stall,
    input kcs_pkg::out_t                   out_data
);
    import kcs_pkg::*;

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("out_valid high right after reset");

    // a sample transaction keeps the input side busy
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.kind == KIND_SAMPLE) |=> in_stall)
        else $error("input not stalled after a sample");

    // a load transaction leaves the block ready
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.kind == KIND_LOAD) |=> !in_stall)
        else $error("input stalled after a load");

    // a held result does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed or dropped");

endmodule

bind keyframe_channel_sampler kcs_checker u_kcs_checker (.*);

### verif/keyframe_channel_sampler_tb.sv
// self-checking testbench for the keyframe channel sampler: key loads, sampling and blending
module keyframe_channel_sampler_tb;

    import kcs_pkg::*;

    localparam int FRAC_ONE = 1 << FRAC_W;

    typedef enum {TABLE_WIDE, TABLE_TIGHT, TABLE_SCRAMBLED} table_style_t;

    class sampler_scoreboard_t;
        logic [31:0]          key_time [MAX_KEYS];
        logic [31:0]          key_x [MAX_KEYS];
        logic [31:0]          key_y [MAX_KEYS];
        logic [31:0]          key_z [MAX_KEYS];
        logic [KEY_CNT_W-1:0] key_count;
        logic                 channel_path;
        out_t                 pending_vectors [$];
        int                   errors;

        function new();
            foreach (key_time[i])
            begin
                key_time[i] = '0;
                key_x[i] = '0;
                key_y[i] = '0;
                key_z[i] = '0;
            end
            key_count = KEY_CNT_W'(1);
            channel_path = 1'b0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_KEY_COUNT)
                key_count = data[KEY_CNT_W-1:0];
            else if (idx == CFG_CHANNEL_PATH)
                channel_path = data[0];
        endfunction

        function int unsigned active_keys();
            if (key_count == 0)
                return 1;
            if (key_count > MAX_KEYS)
                return MAX_KEYS;
            return 32'(key_count);
        endfunction

        function logic [31:0] blend_component(logic [31:0] a, logic [31:0] b, int fr);
            longint s;
            s = longint'($signed(a)) * longint'(FRAC_ONE - fr)
              + longint'($signed(b)) * longint'(fr) + 64'sd32768;
            return 32'(s >>> FRAC_W);
        endfunction

        function out_t sample_channel(logic [31:0] t);
            int unsigned n;
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            int          fr;
            logic [63:0] num;
            logic [63:0] den;
            logic [63:0] q;
            out_t        v;
            n = active_keys();
            fr = 0;
            if (t >= key_time[n-1])
            begin
                lo = n - 1;
                hi = lo;
            end
            else if (t < key_time[0])
            begin
                lo = 0;
                hi = 0;
            end
            else
            begin
                lo = 0;
                hi = n - 1;
                while (hi - lo > 1)
                begin
                    mid = (lo + hi) >> 1;
                    if (key_time[mid] <= t)
                        lo = mid;
                    else
                        hi = mid;
                end
                num = {16'b0, t - key_time[lo], 16'b0};
                den = {32'b0, key_time[hi] - key_time[lo]};
                if (den != 0)
                begin
                    q = num / den;
                    fr = (q > FRAC_ONE - 1) ? FRAC_ONE - 1 : int'(q);
                end
            end
            v.out_x = blend_component(key_x[lo], key_x[hi], fr);
            v.out_y = blend_component(key_y[lo], key_y[hi], fr);
            v.out_z = blend_component(key_z[lo], key_z[hi], fr);
            v.prev_key = lo[KEY_IDX_W-1:0];
            v.target_property = channel_path;
            return v;
        endfunction

        function void note_transaction(in_t tr);
            if (tr.kind == KIND_LOAD)
            begin
                key_time[tr.key_index] = tr.time_value;
                key_x[tr.key_index] = tr.value_x;
                key_y[tr.key_index] = tr.value_y;
                key_z[tr.key_index] = tr.value_z;
            end
            else
                pending_vectors = {pending_vectors, sample_channel(tr.time_value)};
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50)
                $display("mismatch at %0t: %s", $time, msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_vector(out_t got);
            out_t want;
            if (pending_vectors.size() == 0)
                report($sformatf("result %h arrived with no sample pending", got));
            else
            begin
                want = pending_vectors.pop_front();
                compare_field("out_x", got.out_x, want.out_x);
                compare_field("out_y", got.out_y, want.out_y);
                compare_field("out_z", got.out_z, want.out_z);
                compare_field("prev_key", got.prev_key, want.prev_key);
                compare_field("target_property", got.target_property, want.target_property);
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_t                   in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_t                  out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sampler_scoreboard_t sb;
    bit                  steady;
    bit                  hold_request;

    keyframe_channel_sampler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_t make_key(logic [KEY_IDX_W-1:0] idx, logic [31:0] t,
                                     logic [31:0] x, logic [31:0] y, logic [31:0] z);
        in_t tr;
        tr.kind = KIND_LOAD;
        tr.key_index = idx;
        tr.time_value = t;
        tr.value_x = x;
        tr.value_y = y;
        tr.value_z = z;
        return tr;
    endfunction

    function automatic in_t make_load(logic [KEY_IDX_W-1:0] idx, logic [31:0] t);
        return make_key(idx, t, pick_value(), pick_value(), pick_value());
    endfunction

    function automatic in_t make_sample(logic [31:0] t);
        in_t tr;
        tr.kind = KIND_SAMPLE;
        tr.key_index = 6'($urandom);
        tr.time_value = t;
        tr.value_x = $urandom;
        tr.value_y = $urandom;
        tr.value_z = $urandom;
        return tr;
    endfunction

    function automatic logic [31:0] pick_sample_time();
        int unsigned n;
        int unsigned i;
        int          r;
        logic [31:0] lo;
        logic [31:0] hi;
        n = sb.active_keys();
        r = $urandom_range(0, 99);
        if (r < 5)
            return $urandom;
        if (r < 15)
            return $urandom_range(32'hFFFF_FFFF, sb.key_time[n-1]);
        if (r < 25)
            return (sb.key_time[0] == 0) ? $urandom : $urandom_range(sb.key_time[0] - 1, 0);
        if (r < 40 || n < 2)
            return sb.key_time[$urandom_range(0, n - 1)];
        i = $urandom_range(0, n - 2);
        lo = sb.key_time[i];
        hi = sb.key_time[i+1];
        if (r < 45)
            return hi - 1;
        return (hi > lo) ? $urandom_range(hi - 1, lo) : lo;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    task automatic send_transaction(input in_t tr);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_data = tr;
        do @(posedge clk); while (in_stall);
        sb.note_transaction(tr);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending_vectors.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        settle();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_table(input table_style_t style);
        logic [31:0] t;
        int          i;
        int unsigned n;
        n = sb.active_keys();
        t = (style == TABLE_TIGHT) ? $urandom_range(0, 2000) : $urandom_range(0, 1 << 20);
        for (i = 0; i < n; i++)
        begin
            if (style == TABLE_SCRAMBLED && $urandom_range(0, 7) != 0)
                t = $urandom;
            send_transaction(make_load(6'(i), t));
            if (style == TABLE_WIDE)
                t += $urandom_range(1, 1 << 25);
            else if (style == TABLE_TIGHT)
                t += $urandom_range(1, 8);
        end
    endtask

    task automatic run_phase(input logic [KEY_CNT_W-1:0] key_total, input bit path,
                             input table_style_t style, input int items, input bit quiet,
                             input bit hold);
        int r;
        int k;
        int idx;
        write_reg(CFG_KEY_COUNT, key_total);
        write_reg(CFG_CHANNEL_PATH, {6'($urandom), path});
        steady = quiet;
        load_table(style);
        hold_request = hold;
        for (k = 0; k < items; k++)
        begin
            r = $urandom_range(0, 99);
            idx = $urandom_range(0, MAX_KEYS - 1);
            if (r < 84)
                send_transaction(make_sample(pick_sample_time()));
            else if (r < 96)
                send_transaction(make_load(6'(idx), sb.key_time[idx]));
            else if (r < 98)
                send_transaction(make_load(6'(idx), $urandom));
            else
                settle();
        end
        steady = 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side stall pattern
    initial
    begin
        int r;
        int len;
        bit held;
        out_stall = 1'b0;
        held = 1'b0;
        wait (rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (hold_request && !held)
            begin
                held = 1'b1;
                @(negedge clk);
                out_stall = 1'b1;
                repeat (400) @(negedge clk);
            end
            else if (steady || r < 45)
            begin
                len = $urandom_range(1, 24);
                @(negedge clk);
                out_stall = 1'b0;
                repeat (len - 1) @(negedge clk);
            end
            else
            begin
                len = (r < 92) ? $urandom_range(1, 3) : $urandom_range(12, 60);
                @(negedge clk);
                out_stall = 1'b1;
                repeat (len - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_vector(out_data);
        end
    end

    initial
    begin
        logic [31:0] probe [$];
        logic [31:0] t;
        int          i;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_KEY_COUNT;
        cfg_data = '0;
        steady = 1'b0;
        hold_request = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table: extreme values on the first pair, last key at the top of time
        send_transaction(make_key(6'd0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
        send_transaction(make_key(6'd1, 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'hFFFF_FFFF));
        t = 32'h0003_0000;
        for (i = 2; i < MAX_KEYS - 1; i++)
        begin
            send_transaction(make_load(6'(i), t));
            t += $urandom_range(1, 1 << 25);
        end
        send_transaction(make_load(6'(MAX_KEYS - 1), 32'hFFFF_FFFF));

        // reset configuration: a single key
        probe = '{32'h0, 32'h0001_0000, 32'hFFFF_FFFF};
        foreach (probe[k])
            send_transaction(make_sample(probe[k]));

        write_reg(CFG_KEY_COUNT, 7'd64);
        write_reg(CFG_CHANNEL_PATH, 7'd1);
        probe = '{32'h0, 32'h0001_0000, 32'h0001_8000, 32'h0001_FFFF, 32'h0001_0001,
                  sb.key_time[31], sb.key_time[MAX_KEYS-1] - 1, 32'hFFFF_FFFF, 32'h0002_0000};
        foreach (probe[k])
            send_transaction(make_sample(probe[k]));
        send_transaction(make_load(6'd5, sb.key_time[5]));
        send_transaction(make_sample(sb.key_time[5] + 1));

        write_reg(CFG_KEY_COUNT, 7'd2);
        probe = '{32'h0001_C000, 32'h0002_0000, 32'h0000_FFFF};
        foreach (probe[k])
            send_transaction(make_sample(probe[k]));

        run_phase(7'd64, 1'b1, TABLE_WIDE, 90, 1'b0, 1'b1);
        run_phase(7'd1, 1'b0, TABLE_WIDE, 40, 1'b0, 1'b0);
        run_phase(7'd0, 1'b1, TABLE_TIGHT, 40, 1'b0, 1'b0);
        run_phase(7'd127, 1'b0, TABLE_TIGHT, 70, 1'b0, 1'b0);
        run_phase(7'd2, 1'b1, TABLE_WIDE, 50, 1'b0, 1'b0);
        run_phase(7'd64, 1'b0, TABLE_SCRAMBLED, 60, 1'b0, 1'b0);
        run_phase(7'($urandom_range(1, 64)), 1'($urandom), TABLE_WIDE, 70, 1'b1, 1'b0);
        run_phase(7'($urandom_range(65, 127)), 1'b1, TABLE_TIGHT, 60, 1'b0, 1'b0);
        run_phase(7'($urandom_range(3, 64)), 1'($urandom), TABLE_WIDE, 60, 1'b0, 1'b0);
        settle();

        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
rtl/kcs_pkg.sv
rtl/kcs_ram.sv
rtl/kcs_div.sv
rtl/kcs_blend.sv
rtl/keyframe_channel_sampler.sv
rtl/kcs_checker.sv
verif/keyframe_channel_sampler_tb.sv
